[rtl/grs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_pkg
// Shared constants and types for the group reverse stream unit.
// ----------------------------------------------------------------------------
package grs_pkg;

  localparam int MaxGroup   = 64;
  localparam int DataW      = 32;
  localparam int GroupSizeW = 7;
  localparam int CntW       = $clog2(MaxGroup + 1);

  typedef logic [DataW-1:0] data_t;

  typedef enum logic [1:0] {
    SHIFT_HOLD,
    SHIFT_UP,
    SHIFT_DOWN
  } shift_e;

  typedef struct packed {
    shift_e cmd;
  } chain_ctrl_t;

endpackage

[rtl/grs_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_cell
// One storage cell of the chain: holds, takes its lower or its upper neighbor.
// ----------------------------------------------------------------------------
module grs_cell import grs_pkg::*; (
  input  logic        clk_i,
  input  chain_ctrl_t ctrl_i,
  input  data_t       lower_i,
  input  data_t       upper_i,
  output data_t       data_o
);

  data_t data_d, data_q;

  always_comb begin
    case (ctrl_i.cmd)
      SHIFT_UP:   data_d = lower_i;
      SHIFT_DOWN: data_d = upper_i;
      SHIFT_HOLD: data_d = data_q;
      default:    data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[rtl/grs_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_chain
// Row of cells forming a bidirectional shift line of group storage.
// ----------------------------------------------------------------------------
module grs_chain import grs_pkg::*; (
  input  logic        clk_i,
  input  chain_ctrl_t ctrl_i,
  input  data_t       in_data_i,
  output data_t       head_o,
  output data_t       tail_o
);

  data_t cell_data [MaxGroup];

  for (genvar i = 0; i < MaxGroup; i++) begin : g_cell
    data_t lower, upper;
    if (i == 0) begin : g_first
      assign lower = in_data_i;
    end else begin : g_lower
      assign lower = cell_data[i-1];
    end
    if (i == MaxGroup - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_data[i+1];
    end
    grs_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[i])
    );
  end

  assign head_o = cell_data[0];
  assign tail_o = cell_data[MaxGroup-1];

endmodule

[rtl/group_reverse_stream_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_reverse_stream_unit
// Reverses full groups of a configurable size in a stream of signed values.
// ----------------------------------------------------------------------------
// usage
//   in channel: value_i / final_req_i, one element per transfer
//   out channel: value_res_o / final_res_o, registered output stage
//   cfg channel: cfg_group_size_i, always ready, write only while idle
//   group size 0 or 1: each element appears at the output in the cycle
//   after its transfer, one element per cycle while the receiver is ready
//   otherwise elements shift into a row of 64 cells, one per cycle while
//   in_ready_o is high; a full group drains newest first from the head cell,
//   one result per cycle while the receiver is ready; a short trailing
//   group closed by final_req_i first shifts up until its oldest element
//   sits in the tail cell, then drains oldest first, one result per cycle
//   while the receiver is ready; input is held off while a group aligns
//   or drains
//   reset: group size 1, no elements held, output empty
//   a stalled receiver holds the output register and freezes the drain
// ----------------------------------------------------------------------------
module group_reverse_stream_unit import grs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [31:0]    value_i,
  input  logic                  final_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [31:0]    value_res_o,
  output logic                  final_res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [GroupSizeW-1:0] cfg_group_size_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIFO,
    ST_ALIGN,
    ST_FIFO
  } state_e;

  state_e              state_q;
  logic [GroupSizeW-1:0] group_size_q;
  logic [CntW-1:0]     count_q;
  logic [CntW-1:0]     align_q;
  logic                fin_q;
  logic                out_valid_q;
  data_t               out_value_q;
  logic                out_final_q;

  logic [CntW-1:0]     eff_k;
  logic [CntW-1:0]     n_next;
  logic                pass;
  logic                out_free;
  logic                out_load;
  logic                in_xfer;
  logic                cfg_xfer;
  chain_ctrl_t         chain_ctrl;
  data_t               head, tail;

  assign eff_k    = (group_size_q > GroupSizeW'(MaxGroup)) ? CntW'(MaxGroup)
                                                           : CntW'(group_size_q);
  assign pass     = (eff_k <= CntW'(1));
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && !cfg_valid_i && (!pass || out_free);
  assign in_xfer  = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer = cfg_valid_i && cfg_ready_o;
  assign n_next   = count_q + CntW'(1);
  assign out_load = ((state_q == ST_IDLE) && in_xfer && pass) ||
                    (((state_q == ST_LIFO) || (state_q == ST_FIFO)) && out_free);

  always_comb begin
    chain_ctrl.cmd = SHIFT_HOLD;
    case (state_q)
      ST_IDLE:  if (in_xfer && !pass) chain_ctrl.cmd = SHIFT_UP;
      ST_LIFO:  if (out_free) chain_ctrl.cmd = SHIFT_DOWN;
      ST_ALIGN: chain_ctrl.cmd = SHIFT_UP;
      ST_FIFO:  if (out_free) chain_ctrl.cmd = SHIFT_UP;
      default:  chain_ctrl.cmd = SHIFT_HOLD;
    endcase
  end

  grs_chain u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (chain_ctrl),
    .in_data_i (data_t'(value_i)),
    .head_o    (head),
    .tail_o    (tail)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      group_size_q <= GroupSizeW'(1);
      count_q      <= '0;
      align_q      <= '0;
      fin_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_final_q  <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      if (cfg_xfer) begin
        group_size_q <= cfg_group_size_i;
        count_q      <= '0;
      end else begin
        case (state_q)
          ST_IDLE: begin
            if (in_xfer) begin
              if (pass) begin
                out_value_q <= data_t'(value_i);
                out_final_q <= final_req_i;
                count_q     <= '0;
              end else if (n_next == eff_k) begin
                count_q <= n_next;
                fin_q   <= final_req_i;
                state_q <= ST_LIFO;
              end else if (final_req_i) begin
                count_q <= n_next;
                align_q <= CntW'(MaxGroup) - n_next;
                state_q <= ST_ALIGN;
              end else begin
                count_q <= n_next;
              end
            end
          end
          ST_LIFO: begin
            if (out_free) begin
              out_value_q <= head;
              out_final_q <= fin_q && (count_q == CntW'(1));
              count_q     <= count_q - CntW'(1);
              if (count_q == CntW'(1)) state_q <= ST_IDLE;
            end
          end
          ST_ALIGN: begin
            align_q <= align_q - CntW'(1);
            if (align_q == CntW'(1)) state_q <= ST_FIFO;
          end
          ST_FIFO: begin
            if (out_free) begin
              out_value_q <= tail;
              out_final_q <= (count_q == CntW'(1));
              count_q     <= count_q - CntW'(1);
              if (count_q == CntW'(1)) state_q <= ST_IDLE;
            end
          end
          default: state_q <= ST_IDLE;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_res_o = $signed(out_value_q);
  assign final_res_o = out_final_q;

  // no input while a group aligns or drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o)
    else $error("input ready outside idle");

  // draining always has elements left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIFO || state_q == ST_FIFO) |-> (count_q != '0))
    else $error("drain with empty group");

  // a gathering group stays below the group size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !pass) |-> (count_q < eff_k))
    else $error("fill count reached group size while idle");

  // fill count never exceeds the chain length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxGroup))
    else $error("fill count beyond chain length");

endmodule
